@@ rtl/srrw_pkg.sv @@
// ============================================================================
// srrw_pkg : shared types and constants of the receive window
// Result codes, field widths and the control word of the slot walker.
// ============================================================================
package srrw_pkg;

    // result_kind codes
    localparam logic [1:0] RK_HEADER  = 2'd0;
    localparam logic [1:0] RK_MISSING = 2'd1;
    localparam logic [1:0] RK_ERROR   = 2'd2;

    // entries listed after one header at most
    localparam logic [4:0] GAP_CAP = 5'd31;

    // stream widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 80;

    // walker control: load restarts at ack + 1, step moves one slot on
    typedef struct packed {
        logic load;
        logic step;
    } t_walk_ctl;

endpackage

@@ rtl/srrw_slot_map.sv @@
// ============================================================================
// srrw_slot_map : held-slot bitmap
// One flop per window slot, set on store, cleared on in-order release.
// ============================================================================
module srrw_slot_map #(
    parameter  int WINDOW_SLOTS = 32,
    localparam int SLOT_W       = $clog2(WINDOW_SLOTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_set_en,
    input  logic [SLOT_W-1:0] i_set_slot,
    input  logic              i_clr_en,
    input  logic [SLOT_W-1:0] i_clr_slot,
    input  logic [SLOT_W-1:0] i_rd_slot,
    output logic              o_rd_held
);

    logic [WINDOW_SLOTS-1:0] r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else begin
            if (i_set_en) begin
                r_held[i_set_slot] <= 1'b1;
            end
            if (i_clr_en) begin
                r_held[i_clr_slot] <= 1'b0;
            end
        end
    end

    assign o_rd_held = r_held[i_rd_slot];

endmodule

@@ rtl/srrw_walk_unit.sv @@
// ============================================================================
// srrw_walk_unit : shared slot walker
// Index incrementer, wrapping slot pointer and bound compare, reused by
// every pass over the window.
// ============================================================================
module srrw_walk_unit #(
    parameter  int WINDOW_SLOTS = 32,
    localparam int SLOT_W       = $clog2(WINDOW_SLOTS)
) (
    input  logic                     i_clk,
    input  srrw_pkg::t_walk_ctl      i_ctl,
    input  logic signed [31:0]       i_base,
    input  logic [SLOT_W-1:0]        i_base_slot,
    input  logic signed [31:0]       i_bound,
    output logic signed [32:0]       o_pos,
    output logic [SLOT_W-1:0]        o_slot,
    output logic                     o_past
);

    import srrw_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);

    logic signed [32:0] r_pos;
    logic [SLOT_W-1:0]  r_slot;
    logic signed [32:0] w_addend;
    logic signed [32:0] w_sum;

    // one incrementer serves both the restart and the step
    assign w_addend = i_ctl.load ? {i_base[31], i_base} : r_pos;
    assign w_sum    = w_addend + 33'sd1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_pos  <= w_sum;
            r_slot <= i_base_slot;
        end else if (i_ctl.step) begin
            r_pos  <= w_sum;
            r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);
        end
    end

    assign o_pos  = r_pos;
    assign o_slot = r_slot;
    assign o_past = r_pos > {i_bound[31], i_bound};

endmodule

@@ rtl/selective_repeat_receive_window.sv @@
// ============================================================================
// selective_repeat_receive_window : receiver side of a sliding window
// Tracks held sequence slots, acknowledges the in-order index and lists gaps.
// ============================================================================
// One input transfer is taken at a time; o_s_tready is high only while the
// sequencer is idle. After a transfer o_s_tready stays low while metadata,
// early data and dropped items pass the decide state and then the reply or
// check state, and while items that arrive after the finish pass the decide
// state. A data item in the window holds it low, plus any output stall,
// while the walker releases held slots in order and finds the first empty
// slot, walks from the new ack to the largest index seen and ends that pass,
// and walks the slots while listing the missing indices. The sequencer then
// returns to idle before the next transfer. The worst case is a new index at
// the far edge of the window with every slot before it empty. The time is
// set by the single walker, which looks at one bitmap slot per cycle on all
// three passes, except while the listing pass waits on a stalled output. The
// bitmap is in flops and clears at reset, so no start-up sweep is needed.
// ============================================================================
module selective_repeat_receive_window #(
    parameter  int WINDOW_SLOTS = 32,
    localparam int SLOT_W       = $clog2(WINDOW_SLOTS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [srrw_pkg::IN_DATA_W-1:0]    i_s_tdata,  // [30:0] seq_index, [31] zero
    input  logic                              i_s_tuser,  // [0] kind
    input  logic                              i_s_tlast,  // last_packet
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [srrw_pkg::OUT_DATA_W-1:0]   o_m_tdata,  // [31:0] ack_upto, [36:32] gap_count,
                                                          // [42:37] delivered_count,
                                                          // [73:43] missing_index,
                                                          // [74] finished, [79:75] zero
    output logic [1:0]                        o_m_tuser,  // [1:0] result_kind
    output logic                              o_m_tlast   // last
);

    import srrw_pkg::*;

    localparam logic signed [32:0] WIN_POS = 33'(WINDOW_SLOTS);
    localparam logic signed [32:0] WIN_NEG = -WIN_POS;
    localparam logic [SLOT_W:0]    WIN_EXT = (SLOT_W + 1)'(WINDOW_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_REPLY,
        ST_CHECK,
        ST_ADVANCE,
        ST_COUNT,
        ST_HEADER,
        ST_EMIT
    } t_state;

    t_state r_state;

    // window state
    logic signed [31:0] r_in_order;
    logic signed [31:0] r_largest;
    logic [SLOT_W-1:0]  r_base_slot;   // slot of in_order + 1
    logic               r_end_seen;
    logic               r_open;
    logic               r_done;

    // per-item working registers
    logic [30:0]        r_seq;
    logic               r_kind;
    logic               r_last;
    logic               r_reply_err;
    logic signed [32:0] r_diff;        // seq - in_order
    logic [4:0]         r_gaps;
    logic               r_any_gap;
    logic [5:0]         r_deliv;
    logic [4:0]         r_emitted;

    // output register
    logic                  r_o_valid;
    logic [OUT_DATA_W-1:0] r_o_data;
    logic [1:0]            r_o_user;
    logic                  r_o_last;

    // walker and bitmap
    t_walk_ctl          w_walk;
    logic signed [32:0] w_pos;
    logic [SLOT_W-1:0]  w_slot;
    logic               w_past;
    logic               w_held;
    logic               w_set_en;
    logic               w_clr_en;
    logic [SLOT_W-1:0]  w_set_slot;

    logic               w_out_free;
    logic               w_o_load;
    logic               w_in_win;
    logic signed [32:0] w_diff_now;
    logic [SLOT_W-1:0]  w_off;
    logic [SLOT_W:0]    w_slot_sum;
    logic               w_fin;
    logic               w_entry_last;

    assign w_out_free = !r_o_valid || i_m_tready;

    // a result is loaded into the output register this cycle
    assign w_o_load = w_out_free && ((r_state == ST_REPLY) || (r_state == ST_HEADER)
                                     || ((r_state == ST_EMIT) && !w_held));

    assign w_diff_now = $signed({2'b00, r_seq}) - $signed({r_in_order[31], r_in_order});
    assign w_in_win   = !(r_diff > WIN_POS) && !(r_diff < WIN_NEG);

    // slot of a newer index: base slot + (diff - 1), wrapped once
    assign w_off      = r_diff[SLOT_W-1:0] - SLOT_W'(1);
    assign w_slot_sum = {1'b0, r_base_slot} + {1'b0, w_off};
    assign w_set_slot = (w_slot_sum >= WIN_EXT) ? SLOT_W'(w_slot_sum - WIN_EXT)
                                                : w_slot_sum[SLOT_W-1:0];

    assign w_set_en = (r_state == ST_CHECK) && w_in_win && (r_diff > 33'sd0);
    assign w_clr_en = (r_state == ST_ADVANCE) && w_held;

    assign w_fin        = r_end_seen && !r_any_gap;
    assign w_entry_last = (r_emitted + 5'd1) == r_gaps;

    always_comb begin
        w_walk.load = ((r_state == ST_CHECK) && w_in_win)
                   || ((r_state == ST_HEADER) && w_out_free);
        w_walk.step = ((r_state == ST_ADVANCE) && w_held)
                   || ((r_state == ST_COUNT) && !w_past)
                   || ((r_state == ST_EMIT) && (w_held || w_out_free));
    end

    srrw_slot_map #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_slot_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_set_en   (w_set_en),
        .i_set_slot (w_set_slot),
        .i_clr_en   (w_clr_en),
        .i_clr_slot (w_slot),
        .i_rd_slot  (w_slot),
        .o_rd_held  (w_held)
    );

    srrw_walk_unit #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_walk (
        .i_clk       (i_clk),
        .i_ctl       (w_walk),
        .i_base      (r_in_order),
        .i_base_slot (r_base_slot),
        .i_bound     (r_largest),
        .o_pos       (w_pos),
        .o_slot      (w_slot),
        .o_past      (w_past)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_order  <= -32'sd1;
            r_largest   <= -32'sd1;
            r_base_slot <= '0;
            r_end_seen  <= 1'b0;
            r_open      <= 1'b0;
            r_done      <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (w_o_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_m_tready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_seq   <= i_s_tdata[30:0];
                        r_kind  <= i_s_tuser;
                        r_last  <= i_s_tlast;
                        r_state <= ST_DECIDE;
                    end
                end

                ST_DECIDE: begin
                    r_diff <= w_diff_now;
                    priority if (r_done) begin
                        r_state <= ST_IDLE;
                    end else if (!r_kind) begin
                        r_open      <= 1'b1;
                        r_reply_err <= 1'b0;
                        r_state     <= ST_REPLY;
                    end else if (!r_open) begin
                        r_reply_err <= 1'b1;
                        r_state     <= ST_REPLY;
                    end else begin
                        r_state <= ST_CHECK;
                    end
                end

                // single-result answer: open header or early-data error
                ST_REPLY: begin
                    if (w_out_free) begin
                        r_o_last  <= 1'b1;
                        if (r_reply_err) begin
                            r_o_user <= RK_ERROR;
                            r_o_data <= '0;
                        end else begin
                            r_o_user <= RK_HEADER;
                            r_o_data <= {48'd0, {32{1'b1}}};
                        end
                        r_state <= ST_IDLE;
                    end
                end

                ST_CHECK: begin
                    if (!w_in_win) begin
                        r_state <= ST_IDLE;
                    end else begin
                        if ($signed({1'b0, r_seq}) > r_largest) begin
                            r_largest <= {1'b0, r_seq};
                        end
                        r_end_seen <= r_end_seen || r_last;
                        r_gaps     <= '0;
                        r_any_gap  <= 1'b0;
                        r_deliv    <= '0;
                        r_state    <= ST_ADVANCE;
                    end
                end

                // release contiguous held slots; freed slot stops a wrap-round
                ST_ADVANCE: begin
                    if (w_held) begin
                        r_in_order <= w_pos[31:0];
                        r_deliv    <= r_deliv + 6'd1;
                    end else begin
                        r_base_slot <= w_slot;
                        r_state     <= ST_COUNT;
                    end
                end

                // count the gaps up to the largest index seen
                ST_COUNT: begin
                    if (w_past) begin
                        r_state <= ST_HEADER;
                    end else if (!w_held) begin
                        r_any_gap <= 1'b1;
                        if (r_gaps != GAP_CAP) begin
                            r_gaps <= r_gaps + 5'd1;
                        end
                    end
                end

                ST_HEADER: begin
                    if (w_out_free) begin
                        r_o_user  <= RK_HEADER;
                        r_o_last  <= (r_gaps == 5'd0);
                        r_o_data  <= {5'd0, w_fin, 31'd0, r_deliv, r_gaps, r_in_order};
                        if (w_fin) begin
                            r_done <= 1'b1;
                        end
                        r_emitted <= '0;
                        r_state   <= (r_gaps == 5'd0) ? ST_IDLE : ST_EMIT;
                    end
                end

                // second walk: list the missing indices, lowest first
                ST_EMIT: begin
                    if (!w_held && w_out_free) begin
                        r_o_user  <= RK_MISSING;
                        r_o_last  <= w_entry_last;
                        r_o_data  <= {5'd0, 1'b0, w_pos[30:0], 43'd0};
                        r_emitted <= r_emitted + 5'd1;
                        if (w_entry_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_user;
    assign o_m_tlast  = r_o_last;

    // one item at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while an item is in progress");

    // finish is sticky
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("finished flag dropped");

    // the acknowledged index only moves forward
    a_ack_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_in_order >= $past(r_in_order)))
        else $error("in-order index went backwards");

    // nothing acknowledged beyond what has been seen
    a_ack_le_largest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_largest >= r_in_order)
        else $error("in-order index passed the largest index seen");

    // never more entries than the header announced
    a_entry_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_emitted < r_gaps))
        else $error("missing-index entries overran the gap count");

endmodule
